FILE: hw/rtl/tmc_pkg.sv
// shared types and constants for the triangle measure block
package tmc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int SIDE_W = 25;
  localparam int PERIM_W = 27;
  localparam int AREA_W = 40;

  typedef enum logic [1:0] {
    KIND_SCALENE = 2'd0,
    KIND_ISOSCELES = 2'd1,
    KIND_EQUILATERAL = 2'd2
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS_DEF-1:0] ax;
    logic signed [COORD_BITS_DEF-1:0] ay;
    logic signed [COORD_BITS_DEF-1:0] bx;
    logic signed [COORD_BITS_DEF-1:0] by;
    logic signed [COORD_BITS_DEF-1:0] cx;
    logic signed [COORD_BITS_DEF-1:0] cy;
  } tri_in_t;

  typedef struct packed {
    logic [SIDE_W-1:0] side_ab;
    logic [SIDE_W-1:0] side_bc;
    logic [SIDE_W-1:0] side_ca;
    logic [PERIM_W-1:0] perimeter;
    logic [AREA_W-1:0] area;
    logic [1:0] kind;
  } tri_out_t;

endpackage

FILE: hw/rtl/tmc_sqrt_cell.sv
// one restoring square root step, registered
module tmc_sqrt_cell import tmc_pkg::*; #(
  parameter int RAD_W = 66,
  parameter int ROOT_W = 33,
  parameter int STEP = 0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rem_in,
  input  logic [ROOT_W-1:0] root_in,
  output logic [RAD_W-1:0]  rem_out,
  output logic [ROOT_W-1:0] root_out
);

  localparam int SH = 2 * (ROOT_W - 1 - STEP);

  logic [RAD_W+1:0] trial;
  logic [RAD_W+1:0] rem_ext;

  // trial = (2*root+1) << shift, root holds upper bits already decided
  always_comb begin
    trial = ({{(RAD_W+2-ROOT_W){1'b0}}, root_in} << (ROOT_W - STEP))
          | ({{(RAD_W+1){1'b0}}, 1'b1} << SH);
    rem_ext = {2'b00, rem_in};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (rem_ext >= trial) begin
        rem_out <= RAD_W'(rem_ext - trial);
        root_out <= root_in | (ROOT_W'(1) << (ROOT_W - 1 - STEP));
      end else begin
        rem_out <= rem_in;
        root_out <= root_in;
      end
    end
  end

endmodule

FILE: hw/rtl/tmc_sqrt_chain.sv
// pipelined square root built as a row of step cells
module tmc_sqrt_chain import tmc_pkg::*; #(
  parameter int RAD_W = 66,
  parameter int ROOT_W = 33
) (
  input  logic              clk,
  input  logic              en,
  input  logic [RAD_W-1:0]  rad,
  output logic [ROOT_W-1:0] root
);

  logic [RAD_W-1:0] rem_q [ROOT_W+1];
  logic [ROOT_W-1:0] root_q [ROOT_W+1];

  assign rem_q[0] = rad;
  assign root_q[0] = '0;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
    tmc_sqrt_cell #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .STEP(i)) u_cell (
      .clk(clk), .en(en),
      .rem_in(rem_q[i]), .root_in(root_q[i]),
      .rem_out(rem_q[i+1]), .root_out(root_q[i+1])
    );
  end

  assign root = root_q[ROOT_W];

endmodule

FILE: hw/rtl/triangle_measure_classify.sv
// triangle sides, perimeter, area and kind from three corners
// throughput: one request per cycle while not stalled, set by the square root cell chain
// whole pipeline advances together; stalls only when the output register is full
// and not taken
// reset: synchronous, clears the stage valid bits only
module triangle_measure_classify import tmc_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  tri_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output tri_out_t out_data
);

  localparam int D_W = COORD_BITS + 1;
  localparam int Q_W = 2 * D_W + 1;
  localparam int RAD_W = Q_W + 2 * FRAC_BITS + (Q_W + 2 * FRAC_BITS) % 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int CR_W = 2 * D_W + 1;
  localparam int LAT = ROOT_W;

  logic en;
  logic [LAT:0] vld;

  // one stall for the whole pipe, output register acts as the last stage
  assign en = !vld[LAT] || out_ready;
  assign in_ready = en;

  logic signed [COORD_BITS-1:0] ax, ay, bx, by, cx, cy;
  assign ax = COORD_BITS'(in_data.ax);
  assign ay = COORD_BITS'(in_data.ay);
  assign bx = COORD_BITS'(in_data.bx);
  assign by = COORD_BITS'(in_data.by);
  assign cx = COORD_BITS'(in_data.cx);
  assign cy = COORD_BITS'(in_data.cy);

  // stage 0: differences
  logic signed [D_W-1:0] abx, aby, bcx, bcy, cax, cay, acx, acy;
  always_ff @(posedge clk) begin
    if (en) begin
      abx <= D_W'(bx) - D_W'(ax);
      aby <= D_W'(by) - D_W'(ay);
      bcx <= D_W'(cx) - D_W'(bx);
      bcy <= D_W'(cy) - D_W'(by);
      cax <= D_W'(ax) - D_W'(cx);
      cay <= D_W'(ay) - D_W'(cy);
      acx <= D_W'(cx) - D_W'(ax);
      acy <= D_W'(cy) - D_W'(ay);
    end
  end

  // stage 1: products
  logic [2*D_W-1:0] p_abx, p_aby, p_bcx, p_bcy, p_cax, p_cay;
  logic signed [2*D_W-1:0] p_c1, p_c2;
  always_ff @(posedge clk) begin
    if (en) begin
      p_abx <= (2*D_W)'(abx * abx);
      p_aby <= (2*D_W)'(aby * aby);
      p_bcx <= (2*D_W)'(bcx * bcx);
      p_bcy <= (2*D_W)'(bcy * bcy);
      p_cax <= (2*D_W)'(cax * cax);
      p_cay <= (2*D_W)'(cay * cay);
      p_c1 <= abx * acy;
      p_c2 <= aby * acx;
    end
  end

  // stage 2: squared sides, cross magnitude and kind
  logic [Q_W-1:0] q_ab_c, q_bc_c, q_ca_c;
  logic signed [CR_W-1:0] cr_c;
  logic [CR_W-1:0] cr_abs;
  kind_t kind_c;
  always_comb begin
    q_ab_c = Q_W'(p_abx) + Q_W'(p_aby);
    q_bc_c = Q_W'(p_bcx) + Q_W'(p_bcy);
    q_ca_c = Q_W'(p_cax) + Q_W'(p_cay);
    cr_c = CR_W'(p_c1) - CR_W'(p_c2);
    cr_abs = cr_c[CR_W-1] ? CR_W'(-cr_c) : CR_W'(cr_c);
    if (q_ab_c == q_bc_c && q_bc_c == q_ca_c) kind_c = KIND_EQUILATERAL;
    else if (q_ab_c == q_bc_c || q_ab_c == q_ca_c || q_bc_c == q_ca_c)
      kind_c = KIND_ISOSCELES;
    else kind_c = KIND_SCALENE;
  end

  logic [RAD_W-1:0] rad_ab, rad_bc, rad_ca;
  logic [CR_W-1:0] cr_q [LAT+1];
  kind_t kind_q [LAT+1];
  always_ff @(posedge clk) begin
    if (en) begin
      rad_ab <= RAD_W'(q_ab_c) << (2 * FRAC_BITS);
      rad_bc <= RAD_W'(q_bc_c) << (2 * FRAC_BITS);
      rad_ca <= RAD_W'(q_ca_c) << (2 * FRAC_BITS);
      cr_q[0] <= cr_abs;
      kind_q[0] <= kind_c;
      for (int i = 1; i < LAT + 1; i++) begin
        cr_q[i] <= cr_q[i-1];
        kind_q[i] <= kind_q[i-1];
      end
    end
  end

  logic [ROOT_W-1:0] r_ab, r_bc, r_ca;
  tmc_sqrt_chain #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sq_ab (
    .clk(clk), .en(en), .rad(rad_ab), .root(r_ab));
  tmc_sqrt_chain #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sq_bc (
    .clk(clk), .en(en), .rad(rad_bc), .root(r_bc));
  tmc_sqrt_chain #(.RAD_W(RAD_W), .ROOT_W(ROOT_W)) u_sq_ca (
    .clk(clk), .en(en), .rad(rad_ca), .root(r_ca));

  // valid bits: stages 0,1,2, then LAT root cells, output register is vld[LAT]
  logic [2:0] vfront;
  always_ff @(posedge clk) begin
    if (rst) begin
      vfront <= '0;
      vld <= '0;
    end else if (en) begin
      vfront <= {vfront[1:0], in_valid};
      vld <= {vld[LAT-1:0], vfront[2]};
    end
  end

  logic [ROOT_W+1:0] perim_sum;
  logic [CR_W+FRAC_BITS:0] area_full;
  assign perim_sum = (ROOT_W+2)'(r_ab) + (ROOT_W+2)'(r_bc) + (ROOT_W+2)'(r_ca);
  assign area_full = ({1'b0, cr_q[LAT], {FRAC_BITS{1'b0}}}) >> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.side_ab <= SIDE_W'(r_ab);
      out_data.side_bc <= SIDE_W'(r_bc);
      out_data.side_ca <= SIDE_W'(r_ca);
      out_data.perimeter <= PERIM_W'(perim_sum);
      out_data.area <= AREA_W'(area_full);
      out_data.kind <= kind_q[LAT];
    end
  end

  assign out_valid = vld[LAT];

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.kind != 2'd3)
    else $error("bad kind code");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipe moved during stall");

endmodule

FILE: tb/sv/tmc_checker.sv
// checker that predicts triangle measurements and compares them with the block output
module tmc_checker import tmc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  tri_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  tri_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  tri_out_t measure_q[$];

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= root + bit_v) begin
        n = n - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  function automatic tri_out_t measure(tri_in_t t);
    tri_out_t r;
    longint ax, ay, bx, by, cx, cy, cr;
    logic [63:0] q_ab, q_bc, q_ca, s_ab, s_bc, s_ca, acr;
    ax = t.ax; ay = t.ay; bx = t.bx; by = t.by; cx = t.cx; cy = t.cy;
    q_ab = (bx - ax) * (bx - ax) + (by - ay) * (by - ay);
    q_bc = (cx - bx) * (cx - bx) + (cy - by) * (cy - by);
    q_ca = (ax - cx) * (ax - cx) + (ay - cy) * (ay - cy);
    s_ab = isqrt(q_ab << (2 * FRAC_BITS_DEF));
    s_bc = isqrt(q_bc << (2 * FRAC_BITS_DEF));
    s_ca = isqrt(q_ca << (2 * FRAC_BITS_DEF));
    cr = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
    acr = (cr < 0) ? -cr : cr;
    r.side_ab = s_ab[SIDE_W-1:0];
    r.side_bc = s_bc[SIDE_W-1:0];
    r.side_ca = s_ca[SIDE_W-1:0];
    r.perimeter = PERIM_W'(s_ab + s_bc + s_ca);
    r.area = AREA_W'((acr << FRAC_BITS_DEF) >> 1);
    if (q_ab == q_bc && q_bc == q_ca) r.kind = KIND_EQUILATERAL;
    else if (q_ab == q_bc || q_ab == q_ca || q_bc == q_ca) r.kind = KIND_ISOSCELES;
    else r.kind = KIND_SCALENE;
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = measure_q.size();

  always @(posedge clk) begin
    tri_out_t exp_r;
    if (!rst) begin
      if (in_valid && in_ready) measure_q.push_back(measure(in_data));
      if (out_valid && out_ready) begin
        if (measure_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", out_data);
        end else begin
          exp_r = measure_q.pop_front();
          if (exp_r.side_ab !== out_data.side_ab || exp_r.side_bc !== out_data.side_bc ||
              exp_r.side_ca !== out_data.side_ca ||
              exp_r.perimeter !== out_data.perimeter ||
              exp_r.area !== out_data.area || exp_r.kind !== out_data.kind) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("expected %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                exp_r.side_ab, exp_r.side_bc, exp_r.side_ca, exp_r.perimeter,
                exp_r.area, exp_r.kind, out_data.side_ab, out_data.side_bc,
                out_data.side_ca, out_data.perimeter, out_data.area, out_data.kind);
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/tb_triangle_measure_classify.sv
// testbench top: drives triangle requests and reports the verdict
module tb_triangle_measure_classify;
  import tmc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk, rst, in_valid, in_ready, out_valid, out_ready;
  tri_in_t in_data;
  tri_out_t out_data;
  int fail_count, pending;
  int send_idle, recv_idle;

  triangle_measure_classify uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  tmc_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("triangle_measure_classify: mismatch");
    $finish;
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(16)) - 16'd8;
      2: return ($urandom_range(1)) ? 16'h7fff - 16'($urandom_range(3)) :
                                      16'h8000 + 16'($urandom_range(3));
      default: return 16'($urandom_range(400)) - 16'd200;
    endcase
  endfunction

  function automatic tri_in_t rand_tri();
    tri_in_t t;
    int dx, dy;
    t = {rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord()};
    dx = $urandom_range(200) - 100;
    dy = $urandom_range(200) - 100;
    case ($urandom_range(5))
      0: begin
        t.cx = t.bx; t.cy = t.ay + (t.ay - t.by);
        t.cx = t.ax + (t.ax - t.bx); t.cy = t.ay + (t.by - t.ay);
      end
      1: begin
        t.bx = 16'(t.ax + dx); t.by = 16'(t.ay + dy);
        t.cx = 16'(t.ax - dx); t.cy = 16'(t.ay - dy);
      end
      2: begin
        t.bx = 16'(t.ax + dx); t.by = 16'(t.ay + dy);
        t.cx = 16'(t.ax - dy); t.cy = 16'(t.ay + dx);
      end
      default: ;
    endcase
    return t;
  endfunction

  // called at a falling edge, returns at the falling edge after the accepting edge
  task automatic send(tri_in_t t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_data <= t;
    #1;
    while (!in_ready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
  endtask

  initial begin
    tri_in_t t;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    out_ready = 0;
    send_idle = 16;
    recv_idle = 76;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;
    send('0);
    send({16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd4});
    send({16'sd0, 16'sd0, 16'sd4, 16'sd0, 16'sd2, 16'sd3});
    send({16'sd1, 16'sd1, 16'sd2, 16'sd2, 16'sd3, 16'sd3});
    send({16'sd5, 16'sd5, 16'sd5, 16'sd5, 16'sd9, 16'sd1});
    send({16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    send({16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff});
    send({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff});
    send({16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff, 16'shffff});
    send({16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555, 16'sh0, 16'sh0});
    send({16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0, 16'sd1});
    send({16'sd0, 16'sd0, 16'sd1, 16'sd2, 16'sd2, 16'sd1});
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin send_idle = 76; recv_idle = 16; end
      if (p == 2) begin send_idle = 0; recv_idle = 0; end
      for (int i = 0; i < 480; i++) send(rand_tri());
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("triangle_measure_classify: match");
    else $display("triangle_measure_classify: mismatch");
    $finish;
  end
endmodule
